// File: src/smp_pkg.sv
// Shared constants for the second-max 2x2 pooling reduction block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package smp_pkg;

    // Default sizing of the block
    localparam int DEF_MAX_SIDE   = 1024;
    localparam int DEF_VALUE_BITS = 16;

    // Side-log2 configuration register
    localparam int           CFG_W         = 4;
    localparam logic [3:0]   CFG_RESET_VAL = 4'd1;

endpackage

// File: src/smp_ram.sv
// Generic single-port RAM with registered read data.
// Depends on smp_pkg for the default width and depth.
`timescale 1ns / 1ps

module smp_ram
    import smp_pkg::*;
#(
    parameter int WIDTH = DEF_VALUE_BITS,
    parameter int DEPTH = 2 * DEF_MAX_SIDE
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read the addressed word into the output register
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: src/smp_second4.sv
// Shared compare unit: second-largest of four signed values, duplicates counted.
// Depends on smp_pkg for the default value width.
`timescale 1ns / 1ps

module smp_second4
    import smp_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    input  logic [VALUE_BITS-1:0] c,
    input  logic [VALUE_BITS-1:0] d,
    output logic [VALUE_BITS-1:0] y
);

    logic [VALUE_BITS-1:0] hi_ab, lo_ab, hi_cd, lo_cd;
    logic [VALUE_BITS-1:0] lo_of_hi, hi_of_lo;

    // Order each pair
    always_comb begin
        if ($signed(a) >= $signed(b)) begin
            hi_ab = a;
            lo_ab = b;
        end else begin
            hi_ab = b;
            lo_ab = a;
        end
        if ($signed(c) >= $signed(d)) begin
            hi_cd = c;
            lo_cd = d;
        end else begin
            hi_cd = d;
            lo_cd = c;
        end
    end

    // Runner-up is the larger of the smaller pair maximum and the larger pair minimum
    assign lo_of_hi = ($signed(hi_ab) <= $signed(hi_cd)) ? hi_ab : hi_cd;
    assign hi_of_lo = ($signed(lo_ab) >= $signed(lo_cd)) ? lo_ab : lo_cd;
    assign y        = ($signed(lo_of_hi) >= $signed(hi_of_lo)) ? lo_of_hi : hi_of_lo;

endmodule

// File: src/second_max_pooling_reduce_unit.sv
// Top level of the second-max 2x2 pooling reduction block: sequencer,
// level counters, config register and output register.
// Depends on smp_pkg, smp_ram and smp_second4.
`timescale 1ns / 1ps

// Usage
//   Program side_log2 through the cfg channel (cfg_valid/cfg_ready/cfg_data)
//   while no matrix is in flight; each write also restarts the matrix.
//   Stream the 2^k x 2^k matrix row-major on s_axis_*, one element per
//   transfer. On the transfer of the last element the block emits one
//   result transfer on m_axis_* holding the reduced value; other elements
//   give no result.
// Sequence
//   An element that completes no 2x2 block is accepted in ST_IDLE, then one
//   sequencer step writes it into the row store or the pending-left register.
//   Each completed block adds two reads of the single RAM port for the
//   stored upper pair, then one pass through the shared compare unit,
//   after which the value cascades to the next level. No new element is
//   accepted until the sequencer is back in ST_IDLE.
// Reset and stall
//   Reset sets side_log2 to 1 and clears all level counters; the row store
//   needs no clearing. A stalled receiver does not stop input until a new
//   result is ready while the previous one still waits; the sequencer then
//   holds that result until the output register frees up.
module second_max_pooling_reduce_unit
    import smp_pkg::*;
#(
    parameter int MAX_SIDE   = DEF_MAX_SIDE,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [CFG_W-1:0]                   cfg_data,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // [VALUE_BITS-1:0] value
    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [((VALUE_BITS+7)/8)*8-1:0]    m_axis_tdata    // [VALUE_BITS-1:0] result
);

    localparam int DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
    localparam int MAX_LOG2 = $clog2(MAX_SIDE + 1) - 1;
    localparam int NUM_LVL  = MAX_LOG2 + 1;
    localparam int LVL_W    = $clog2(NUM_LVL);
    localparam int CNT_W    = MAX_LOG2;
    localparam int SIDE_W   = MAX_LOG2 + 1;
    localparam int DEPTH    = 2 * MAX_SIDE;
    localparam int ADDR_W   = $clog2(DEPTH);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_STEP = 2'd1;
    localparam logic [1:0] ST_RDA  = 2'd2;
    localparam logic [1:0] ST_RDB  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CFG_W-1:0]      side_log2_reg;
    logic [LVL_W-1:0]      level_reg, level_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] upa_reg, upa_next;
    logic [CNT_W-1:0]      col_reg [NUM_LVL];
    logic [CNT_W-1:0]      row_reg [NUM_LVL];
    logic [VALUE_BITS-1:0] left_reg [NUM_LVL];
    logic                  m_valid_reg;
    logic [VALUE_BITS-1:0] m_data_reg;

    logic [LVL_W-1:0]      k_eff;
    logic [SIDE_W-1:0]     side_full, s_full;
    logic [SIDE_W:0]       base_full;
    logic [ADDR_W-1:0]     addr_cur, addr_left, ram_addr;
    logic [CNT_W-1:0]      col_cur, row_cur, last_idx, col_next, row_next;
    logic                  ram_we, cnt_upd, left_we, out_load, out_free, cfg_fire;
    logic [VALUE_BITS-1:0] ram_rdata, pooled;

    // Clamp the programmed side to what the row store can hold
    assign k_eff = (int'(side_log2_reg) > MAX_LOG2) ? LVL_W'(MAX_LOG2) : LVL_W'(side_log2_reg);

    // Level geometry: side of this level and its offset in the row store
    assign side_full = SIDE_W'(1) << k_eff;
    assign s_full    = side_full >> level_reg;
    assign base_full = {side_full, 1'b0} - {s_full, 1'b0};
    assign last_idx  = CNT_W'(s_full - SIDE_W'(1));

    assign col_cur   = col_reg[level_reg];
    assign row_cur   = row_reg[level_reg];
    assign addr_cur  = ADDR_W'(base_full) + ADDR_W'(col_cur);
    assign addr_left = addr_cur - ADDR_W'(1);

    // Advance the position counter of the current level
    assign col_next = (col_cur == last_idx) ? '0 : col_cur + CNT_W'(1);
    assign row_next = (col_cur != last_idx) ? row_cur :
                      (row_cur == last_idx) ? '0 : row_cur + CNT_W'(1);

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // Row store of all levels
    smp_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_row_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (val_reg),
        .rdata (ram_rdata)
    );

    // Shared compare unit
    smp_second4 #(
        .VALUE_BITS (VALUE_BITS)
    ) u_second4 (
        .a (upa_reg),
        .b (ram_rdata),
        .c (left_reg[level_reg]),
        .d (val_reg),
        .y (pooled)
    );

    // Sequencer: one level per step, cascading completed blocks upward
    always_comb begin
        state_next = state_reg;
        level_next = level_reg;
        val_next   = val_reg;
        upa_next   = upa_reg;
        ram_we     = 1'b0;
        ram_addr   = addr_cur;
        cnt_upd    = 1'b0;
        left_we    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    val_next   = s_axis_tdata[VALUE_BITS-1:0];
                    level_next = '0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (level_reg == k_eff) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (!row_cur[0]) begin
                    ram_we     = 1'b1;
                    cnt_upd    = 1'b1;
                    state_next = ST_IDLE;
                end else if (!col_cur[0]) begin
                    left_we    = 1'b1;
                    cnt_upd    = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    ram_addr   = addr_left;
                    state_next = ST_RDA;
                end
            end
            ST_RDA: begin
                upa_next   = ram_rdata;
                state_next = ST_RDB;
            end
            ST_RDB: begin
                val_next   = pooled;
                cnt_upd    = 1'b1;
                level_next = level_reg + LVL_W'(1);
                state_next = ST_STEP;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and level counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            side_log2_reg <= CFG_RESET_VAL;
            level_reg     <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_LVL; i++) begin
                col_reg[i] <= '0;
                row_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            level_reg <= level_next;
            if (cfg_fire) begin
                side_log2_reg <= cfg_data;
                for (int i = 0; i < NUM_LVL; i++) begin
                    col_reg[i] <= '0;
                    row_reg[i] <= '0;
                end
            end else if (cnt_upd) begin
                col_reg[level_reg] <= col_next;
                row_reg[level_reg] <= row_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        upa_reg <= upa_next;
        if (left_we) begin
            left_reg[level_reg] <= val_reg;
        end
        if (out_load) begin
            m_data_reg <= val_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = DATA_W'(m_data_reg);

endmodule

// File: tb/tb_second_max_pooling_reduce_unit.sv
// Self-checking testbench for second_max_pooling_reduce_unit: streams square
// matrices through the block and checks each reduced value against a built-in
// level-by-level pooling predictor. Depends on smp_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_second_max_pooling_reduce_unit;
    import smp_pkg::*;

    localparam int VB       = DEF_VALUE_BITS;
    localparam int TDW      = ((VB + 7) / 8) * 8;
    localparam int LEVELS   = 13;
    localparam int ROW_MEM  = 2 * DEF_MAX_SIDE;
    localparam int MAX_LOG2 = 10;
    localparam int SETTLE   = 2 + 3 * MAX_LOG2 + 8;

    logic aclk;
    logic aresetn = 1'b0;

    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [TDW-1:0] s_axis_tdata  = '0;    // [15:0] value

    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [TDW-1:0] m_axis_tdata;          // [15:0] result

    // Stimulus and scoreboard storage
    logic [VB-1:0]        pending_values[$];
    logic signed [VB-1:0] expected_results[$];
    int                   n_errors = 0;
    bit                   idle_on = 1'b1;
    bit                   item_accepted = 1'b0;
    int                   src_gap = 0;
    int                   sink_stall = 0;
    logic signed [VB-1:0] mon_result;

    // Predictor state
    logic [CFG_W-1:0]     side_cfg;
    logic signed [VB-1:0] row_store [ROW_MEM];
    logic signed [VB-1:0] left_value [LEVELS];
    int                   lvl_col [LEVELS];
    int                   lvl_row [LEVELS];

    second_max_pooling_reduce_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Clamp the programmed side so that it fits the row store
    function automatic int eff_log2(input logic [CFG_W-1:0] cfg);
        int k;
        k = cfg;
        while (k > 0 && (1 << k) > DEF_MAX_SIDE)
            k--;
        return k;
    endfunction

    function automatic void clear_levels();
        for (int i = 0; i < LEVELS; i++) begin
            lvl_col[i] = 0;
            lvl_row[i] = 0;
        end
    endfunction

    // Second largest of four, ties counted separately
    function automatic logic signed [VB-1:0] second_largest(
        input logic signed [VB-1:0] a, b, c, d);
        logic signed [VB-1:0] v [4];
        logic signed [VB-1:0] t;
        v[0] = a; v[1] = b; v[2] = c; v[3] = d;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3 - i; j++) begin
                if (v[j] < v[j + 1]) begin
                    t = v[j];
                    v[j] = v[j + 1];
                    v[j + 1] = t;
                end
            end
        end
        return v[1];
    endfunction

    // Push one element through the pooling levels; returns 1 with the final
    // value when the element completes the matrix.
    function automatic bit pool_reduce_step(input logic signed [VB-1:0] elem,
                                            output logic signed [VB-1:0] final_val);
        int k, side, s, base, c, r;
        logic signed [VB-1:0] v, pooled;
        bit cascade;
        k = eff_log2(side_cfg);
        side = 1 << k;
        v = elem;
        final_val = '0;
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            if (lvl == k) begin
                final_val = v;
                return 1'b1;
            end
            s = side >> lvl;
            base = 2 * side - 2 * s;
            c = lvl_col[lvl];
            r = lvl_row[lvl];
            if (c >= s) c = 0;
            if (r >= s) r = 0;
            cascade = 1'b0;
            pooled = '0;
            if ((r & 1) == 0) begin
                row_store[(base + c) % ROW_MEM] = v;
            end else if ((c & 1) == 0) begin
                left_value[lvl] = v;
            end else begin
                pooled = second_largest(row_store[(base + c - 1) % ROW_MEM],
                                        row_store[(base + c) % ROW_MEM],
                                        left_value[lvl], v);
                cascade = 1'b1;
            end
            c++;
            if (c == s) begin
                c = 0;
                r++;
                if (r == s) r = 0;
            end
            lvl_col[lvl] = c;
            lvl_row[lvl] = r;
            if (!cascade) return 1'b0;
            v = pooled;
        end
        return 1'b0;
    endfunction

    // Monitor: track config and input transfers, check result transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            item_accepted = 1'b0;
            side_cfg = CFG_RESET_VAL;
            clear_levels();
        end else begin
            item_accepted = s_axis_tvalid && s_axis_tready;
            if (cfg_valid && cfg_ready) begin
                side_cfg = cfg_data;
                clear_levels();
            end
            if (item_accepted && pool_reduce_step(s_axis_tdata[VB-1:0], mon_result))
                expected_results.insert(expected_results.size(), mon_result);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result: no value expected, actual %0d",
                           $signed(m_axis_tdata[VB-1:0]));
                    n_errors++;
                end else begin
                    mon_result = expected_results.pop_front();
                    if (m_axis_tdata[VB-1:0] !== mon_result) begin
                        $error("result: expected %0d, actual %0d", mon_result,
                               $signed(m_axis_tdata[VB-1:0]));
                        n_errors++;
                    end
                end
            end
        end
    end

    // Source driver: advance to the next element once the current one is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || item_accepted) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_values.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(1, 14) - 1;
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tdata  <= pending_values.pop_front();
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Sink driver: stall the result channel in random bursts while idle_on is set
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_stall = $urandom_range(1, 14) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Hold until every element is taken and every result has come back
    task automatic wait_drained();
        while (pending_values.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // Reprogram the side once the block is idle
    task automatic set_side(input logic [CFG_W-1:0] val);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mix of extremes, small values with many ties, and full-range values
    function automatic logic [VB-1:0] rand_value();
        logic [VB-1:0] x;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 3))
                    0: x = 16'h8000;
                    1: x = 16'h7fff;
                    2: x = 16'h0000;
                    default: x = 16'hffff;
                endcase
            end
            1: x = VB'($urandom_range(0, 6) - 3);
            default: x = VB'($urandom);
        endcase
        return x;
    endfunction

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            pending_values.insert(pending_values.size(), rand_value());
    endtask

    // Stimulus
    initial begin
        int rand_items, k, side, n, lim;
        logic [CFG_W-1:0] cfg;
        rand_items = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: 2x2 matrices at the reset side, then side-one singles
        pending_values = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                           16'h8000, 16'h8000, 16'h8000, 16'h8000,
                           16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                           16'h0001, 16'h0002, 16'h0003, 16'h0004,
                           16'hffff, 16'h0000, 16'hfffe, 16'h7fff};
        set_side(4'd0);
        pending_values = '{16'h0000, 16'hffff, 16'h7fff, 16'h8000, 16'h5555};

        // Oversized and large sides; all but the 16x16 one abandoned mid-matrix by the next write
        set_side(4'd15);
        queue_random(40);
        set_side(4'd4);
        queue_random(256);
        set_side(4'd10);
        queue_random(120);
        set_side(4'd7);
        queue_random(270);

        // Random phases: mostly whole matrices, some cut short
        while (rand_items < 360) begin
            if (rand_items >= 260) idle_on = 1'b0;
            if ($urandom_range(0, 7) == 0) begin
                cfg  = CFG_W'($urandom_range(1, 15));
                side = 1 << eff_log2(cfg);
                lim  = (side * side - 1 < 150) ? side * side - 1 : 150;
                n    = $urandom_range(1, lim);
            end else begin
                k = $urandom_range(0, 19);
                k = (k < 6) ? 0 : (k < 13) ? 1 : (k < 17) ? 2 : (k < 19) ? 3 : 4;
                cfg  = CFG_W'(k);
                side = 1 << k;
                n    = side * side * ((k >= 3) ? 1 : $urandom_range(1, 4));
            end
            set_side(cfg);
            queue_random(n);
            rand_items += n;
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (n_errors == 0)
            $display("second_max_pooling_reduce_unit regression: pass");
        else
            $display("second_max_pooling_reduce_unit regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("second_max_pooling_reduce_unit regression: fail");
        $finish;
    end

endmodule
